// ===== design/chkdf_pkg.sv =====
// Shared types, constants and helper functions for the chunked body deframer.
package chkdf_pkg;

    // Width of the chunk length counters.
    localparam int LENGTH_BITS = 24;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    // Character codes used by the parser.
    localparam logic [7:0] ASCII_TAB = 8'h09;
    localparam logic [7:0] ASCII_LF  = 8'h0A;
    localparam logic [7:0] ASCII_CR  = 8'h0D;
    localparam logic [7:0] ASCII_SP  = 8'h20;
    localparam logic [7:0] ASCII_0   = 8'h30;
    localparam logic [7:0] ASCII_9   = 8'h39;
    localparam logic [7:0] ASCII_UA  = 8'h41;
    localparam logic [7:0] ASCII_UF  = 8'h46;
    localparam logic [7:0] ASCII_LA  = 8'h61;
    localparam logic [7:0] ASCII_LFC = 8'h66;

    // Matched header terminator prefix length that completes CR LF CR LF.
    localparam logic [1:0] TERM_LAST = 2'd3;
    // Bytes skipped after the data of each chunk.
    localparam logic [1:0] TAIL_SKIP = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_SKIPHEAD,
        PH_BODY,
        PH_SKIPTAIL,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        OUT_ZERO  = 2'd0,
        OUT_BAD   = 2'd1,
        OUT_NOHDR = 2'd2,
        OUT_TRUNC = 2'd3
    } t_outcome;

    // One input request.
    typedef struct packed {
        logic [7:0] byte_value;
        logic       buffer_end;
    } t_in_item;

    // One result request.
    typedef struct packed {
        logic [7:0] body_byte;
        logic       byte_valid;
        logic       chunk_end;
        logic       stream_end;
        t_outcome   outcome;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // Decode one hex digit in either case.
    function automatic t_hex hex_digit(input logic [7:0] b);
        t_hex h;
        h.ok  = 1'b0;
        h.val = 4'd0;
        if (b >= ASCII_0 && b <= ASCII_9) begin
            h.ok  = 1'b1;
            h.val = b[3:0];
        end else if ((b >= ASCII_LA && b <= ASCII_LFC) || (b >= ASCII_UA && b <= ASCII_UF)) begin
            h.ok  = 1'b1;
            h.val = b[3:0] + 4'd9;
        end
        return h;
    endfunction

    // Space, TAB, LF, VT, FF or CR.
    function automatic logic is_space(input logic [7:0] b);
        return (b == ASCII_SP) || (b >= ASCII_TAB && b <= ASCII_CR);
    endfunction

endpackage

// ===== design/chkdf_if.sv =====
// Valid/ready channel interfaces for the deframer's input bytes and results.
interface chkdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       buffer_end;

    modport source (output valid, output byte_value, output buffer_end, input ready);
    modport sink (input valid, input byte_value, input buffer_end, output ready);
endinterface

interface chkdf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] body_byte;
    logic       byte_valid;
    logic       chunk_end;
    logic       stream_end;
    logic [1:0] outcome;

    modport source (output valid, output body_byte, output byte_valid, output chunk_end,
                    output stream_end, output outcome, input ready);
    modport sink (input valid, input body_byte, input byte_valid, input chunk_end,
                  input stream_end, input outcome, output ready);
endinterface

// ===== design/chkdf_in_stage.sv =====
// Input register stage: captures one byte request and holds it until the parser takes it.
module chkdf_in_stage
    import chkdf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_ready,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;
    logic     s_load;

    // The slot frees up in the same cycle the parser consumes it.
    assign o_ready = !r_valid || i_take;
    assign s_load  = i_valid && o_ready;

    // Occupancy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== design/chkdf_parser.sv =====
// Per-byte parser: header hunt, chunk length decode, body pass-through and outcome.
module chkdf_parser
    import chkdf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    input  logic     i_out_room,
    output logic     o_take,
    output logic     o_res_valid,
    output t_result  o_res
);

    t_phase                 r_phase, n_phase;
    logic [1:0]             r_match, n_match;
    logic [LENGTH_BITS-1:0] r_acc, n_acc;
    logic                   r_digits, n_digits;
    logic [LENGTH_BITS-1:0] r_remain, n_remain;
    t_outcome               r_final, n_final;

    logic                   s_data;
    logic                   s_cend;
    logic                   s_produce;
    t_outcome               s_code;
    t_hex                   s_hex;
    logic [7:0]             s_b;
    logic [LENGTH_BITS-1:0] s_dec;
    logic [1:0]             s_mdec;

    assign s_b   = i_item.byte_value;
    assign s_hex = hex_digit(s_b);

    // An item that yields a result waits for space in the result register.
    assign s_produce   = s_data || i_item.buffer_end;
    assign o_take      = i_valid && (i_out_room || !s_produce);
    assign o_res_valid = o_take && s_produce;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_match  <= 2'd0;
            r_acc    <= '0;
            r_digits <= 1'b0;
            r_remain <= '0;
            r_final  <= OUT_ZERO;
        end else if (o_take) begin
            r_phase  <= n_phase;
            r_match  <= n_match;
            r_acc    <= n_acc;
            r_digits <= n_digits;
            r_remain <= n_remain;
            r_final  <= n_final;
        end
    end

    // Next state and result for the byte in the input register.
    always_comb begin
        n_phase  = r_phase;
        n_match  = r_match;
        n_acc    = r_acc;
        n_digits = r_digits;
        n_remain = r_remain;
        n_final  = r_final;
        s_data   = 1'b0;
        s_cend   = 1'b0;
        s_code   = OUT_ZERO;
        s_dec    = (r_remain != '0) ? r_remain - 1'b1 : '0;
        s_mdec   = (r_match != 2'd0) ? r_match - 2'd1 : 2'd0;

        case (r_phase)
            PH_HEADER: begin
                if (s_b == (r_match[0] ? ASCII_LF : ASCII_CR)) begin
                    if (r_match == TERM_LAST) begin
                        n_match  = 2'd0;
                        n_acc    = '0;
                        n_digits = 1'b0;
                        n_phase  = PH_LENGTH;
                    end else begin
                        n_match = r_match + 2'd1;
                    end
                end else begin
                    n_match = (s_b == ASCII_CR) ? 2'd1 : 2'd0;
                end
            end
            PH_LENGTH: begin
                if (s_hex.ok) begin
                    // Saturate once any of the top nibble would shift out.
                    n_acc    = (|r_acc[LENGTH_BITS-1 -: 4]) ? LEN_MAX
                             : {r_acc[LENGTH_BITS-5:0], s_hex.val};
                    n_digits = 1'b1;
                end else if (is_space(s_b) && !r_digits) begin
                    n_phase = PH_LENGTH;
                end else if (!r_digits) begin
                    n_phase = PH_DONE;
                    n_final = OUT_BAD;
                end else if (r_acc == '0) begin
                    n_phase = PH_DONE;
                    n_final = OUT_ZERO;
                end else begin
                    n_phase = PH_SKIPHEAD;
                end
            end
            PH_SKIPHEAD: begin
                n_remain = r_acc;
                n_phase  = PH_BODY;
            end
            PH_BODY: begin
                s_data   = 1'b1;
                n_remain = s_dec;
                if (s_dec == '0) begin
                    s_cend  = 1'b1;
                    n_match = TAIL_SKIP;
                    n_phase = PH_SKIPTAIL;
                end
            end
            PH_SKIPTAIL: begin
                n_match = s_mdec;
                if (s_mdec == 2'd0) begin
                    n_acc    = '0;
                    n_digits = 1'b0;
                    n_phase  = PH_LENGTH;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        // Outcome reported on the buffer's final byte, then back to header search.
        if (i_item.buffer_end) begin
            case (n_phase)
                PH_HEADER: s_code = OUT_NOHDR;
                PH_LENGTH: begin
                    if (!n_digits) begin
                        s_code = OUT_BAD;
                    end else if (n_acc == '0) begin
                        s_code = OUT_ZERO;
                    end else begin
                        s_code = OUT_TRUNC;
                    end
                end
                PH_DONE: s_code = n_final;
                default: s_code = OUT_TRUNC;
            endcase
            n_phase  = PH_HEADER;
            n_match  = 2'd0;
            n_acc    = '0;
            n_digits = 1'b0;
            n_remain = '0;
            n_final  = OUT_ZERO;
        end
    end

    // Result fields.
    always_comb begin
        o_res.body_byte  = s_data ? s_b : 8'd0;
        o_res.byte_valid = s_data;
        o_res.chunk_end  = s_cend;
        o_res.stream_end = i_item.buffer_end;
        o_res.outcome    = s_code;
    end

endmodule

// ===== design/chkdf_out_stage.sv =====
// Result register stage: holds one result request until the downstream side takes it.
module chkdf_out_stage
    import chkdf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_ready
);

    logic    r_valid;
    t_result r_res;

    // Room when empty or when the held result leaves this cycle.
    assign o_room = !r_valid || i_ready;

    // Occupancy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== design/http_chunked_body_deframer_top.sv =====
// A byte accepted into the input register is parsed from there, and its result is held in the result register.
// Throughput: one byte per cycle; the per-byte parse step is a single pass between the
// input register and the result register, so the only stalls come from output backpressure.
// Bytes that yield no result are consumed without taking a result slot.
// Reset (synchronous, active low) empties both registers and returns the parser to
// header search with a cleared length, count and outcome.
module http_chunked_body_deframer_top
    import chkdf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    chkdf_in_if.sink    i_in,
    chkdf_out_if.source o_out
);

    t_in_item s_in_item;
    t_in_item s_pend_item;
    logic     s_pend_valid;
    logic     s_take;
    logic     s_res_valid;
    t_result  s_res;
    logic     s_out_room;
    logic     s_out_valid;
    t_result  s_out_res;

    assign s_in_item.byte_value = i_in.byte_value;
    assign s_in_item.buffer_end = i_in.buffer_end;

    // Input register.
    chkdf_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_item  (s_in_item),
        .o_ready (i_in.ready),
        .i_take  (s_take),
        .o_valid (s_pend_valid),
        .o_item  (s_pend_item)
    );

    // Parse step.
    chkdf_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_pend_valid),
        .i_item      (s_pend_item),
        .i_out_room  (s_out_room),
        .o_take      (s_take),
        .o_res_valid (s_res_valid),
        .o_res       (s_res)
    );

    // Result register.
    chkdf_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s_res_valid),
        .i_res   (s_res),
        .o_room  (s_out_room),
        .o_valid (s_out_valid),
        .o_res   (s_out_res),
        .i_ready (o_out.ready)
    );

    assign o_out.valid      = s_out_valid;
    assign o_out.body_byte  = s_out_res.body_byte;
    assign o_out.byte_valid = s_out_res.byte_valid;
    assign o_out.chunk_end  = s_out_res.chunk_end;
    assign o_out.stream_end = s_out_res.stream_end;
    assign o_out.outcome    = s_out_res.outcome;

    // A result is only produced when the result register can take it.
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_res_valid |-> s_out_room)
        else $error("result produced with no room in the result register");

    // Every presented result carries a data byte or the end of the buffer.
    a_res_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.byte_valid || o_out.stream_end))
        else $error("empty result presented");

    // A chunk end mark only rides on a data byte.
    a_cend_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.chunk_end) |-> o_out.byte_valid)
        else $error("chunk end without a data byte");

    // The outcome field stays zero except on the buffer's final result.
    a_outcome_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.stream_end) |-> (o_out.outcome == OUT_ZERO))
        else $error("outcome reported before the end of the buffer");

endmodule
